>>> rtl/rsr_pkg.sv
// Package for the record sort and rank block: record type, widths, cell control.
package rsr_pkg;

    localparam int ID_W    = 31;
    localparam int NAME_W  = 64;
    localparam int SCORE_W = 16;
    localparam int RANK_W  = 7;
    localparam int MAX_RECORDS_DEF = 64;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [NAME_W-1:0]  name;
        logic [SCORE_W-1:0] score;
    } t_rec;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;   // insert the incoming word into the sorted row
        logic setup;  // copy own score into the ring, clear the count
        logic rank;   // rotate the ring one place and count higher scores
        logic shift;  // move every record one place toward cell 0
    } t_cell_ctl;

endpackage

>>> rtl/rsr_cell.sv
// One cell of the row: holds one record, its rank count and one ring slot.
module rsr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsr_pkg::t_cell_ctl          i_ctl,
    input  rsr_pkg::t_rec               i_new,
    input  rsr_pkg::t_rec               i_left_rec,
    input  logic                        i_left_vld,
    input  logic                        i_left_ins,
    input  rsr_pkg::t_rec               i_right_rec,
    input  logic                        i_right_vld,
    input  logic [rsr_pkg::RANK_W-1:0]  i_right_cnt,
    input  logic [rsr_pkg::SCORE_W-1:0] i_ring_score,
    input  logic                        i_ring_vld,
    output rsr_pkg::t_rec               o_rec,
    output logic                        o_vld,
    output logic                        o_ins,
    output logic [rsr_pkg::RANK_W-1:0]  o_cnt,
    output logic [rsr_pkg::SCORE_W-1:0] o_ring_score,
    output logic                        o_ring_vld
);

    rsr_pkg::t_rec               r_rec;
    logic                        r_vld;
    logic [rsr_pkg::RANK_W-1:0]  r_cnt;
    logic [rsr_pkg::SCORE_W-1:0] r_ring_score;
    logic                        r_ring_vld;
    logic                        new_first;

    // New word sorts ahead of the held one: lower id, or same id and higher score
    assign new_first = (i_new.id < r_rec.id) ||
                       ((i_new.id == r_rec.id) && (i_new.score > r_rec.score));
    assign o_ins     = !r_vld || new_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.load && o_ins) begin
            r_vld <= i_left_ins ? i_left_vld : 1'b1;
        end else if (i_ctl.shift) begin
            r_vld <= i_right_vld;
        end
    end

    // Hold payload, open a gap for the new word, advance toward the head, or set up and rotate the ring
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && o_ins) begin
            r_rec <= i_left_ins ? i_left_rec : i_new;
        end else if (i_ctl.shift) begin
            r_rec <= i_right_rec;
            r_cnt <= i_right_cnt;
        end else if (i_ctl.setup) begin
            r_cnt        <= '0;
            r_ring_score <= r_rec.score;
            r_ring_vld   <= r_vld;
        end else if (i_ctl.rank) begin
            if (i_ring_vld && (i_ring_score > r_rec.score))
                r_cnt <= r_cnt + 1'b1;
            r_ring_score <= i_ring_score;
            r_ring_vld   <= i_ring_vld;
        end
    end

    assign o_rec        = r_rec;
    assign o_vld        = r_vld;
    assign o_cnt        = r_cnt;
    assign o_ring_score = r_ring_score;
    assign o_ring_vld   = r_ring_vld;

endmodule

>>> rtl/record_sort_and_rank.sv
// Top level: load sequencer, row of sorting cells and result register.
// Records load one per cycle (busy low) and are kept sorted by id, then by
// descending score, then load order. After the word marked last the block
// is busy in a setup state, then while scores rotate once around the
// ring of cells to count higher scores, and then, with N records held,
// while the row shifts out through cell 0, one result per cycle. Each result
// shows for one cycle with o_valid; the receiver cannot stall it, so it must
// take every result as it comes.
module record_sort_and_rank #(
    parameter int MAX_RECORDS = rsr_pkg::MAX_RECORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rsr_pkg::ID_W-1:0]    i_record_id,
    input  logic [rsr_pkg::NAME_W-1:0]  i_record_name,
    input  logic [rsr_pkg::SCORE_W-1:0] i_record_score,
    input  logic                        i_is_last,
    output logic                        o_valid,
    output logic [rsr_pkg::ID_W-1:0]    o_out_id,
    output logic [rsr_pkg::NAME_W-1:0]  o_out_name,
    output logic [rsr_pkg::SCORE_W-1:0] o_out_score,
    output logic [rsr_pkg::RANK_W-1:0]  o_out_rank,
    output logic                        o_out_last,
    output logic                        o_overflow
);

    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int STEP_W = $clog2(MAX_RECORDS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_RANK  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic                r_drop;
    logic [STEP_W-1:0]   r_step;
    logic                accept;
    logic                room;
    rsr_pkg::t_cell_ctl  ctl;
    rsr_pkg::t_rec       new_rec;

    rsr_pkg::t_rec               c_rec   [MAX_RECORDS];
    logic                        c_vld   [MAX_RECORDS];
    logic                        c_ins   [MAX_RECORDS];
    logic [rsr_pkg::RANK_W-1:0]  c_cnt   [MAX_RECORDS];
    logic [rsr_pkg::SCORE_W-1:0] c_rscore[MAX_RECORDS];
    logic                        c_rvld  [MAX_RECORDS];

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign room   = (r_count < CNT_W'(MAX_RECORDS));

    assign new_rec.id    = i_record_id;
    assign new_rec.name  = i_record_name;
    assign new_rec.score = i_record_score;

    assign ctl.load  = accept && room;
    assign ctl.setup = (r_state == S_SETUP);
    assign ctl.rank  = (r_state == S_RANK);
    assign ctl.shift = (r_state == S_EMIT);

    // Row of cells: sorted insert from the left, ring rotation, drain to cell 0
    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        localparam int PREV = (g + MAX_RECORDS - 1) % MAX_RECORDS;
        rsr_pkg::t_rec              left_rec, right_rec;
        logic                       left_vld, left_ins, right_vld;
        logic [rsr_pkg::RANK_W-1:0] right_cnt;

        if (g == 0) begin : g_head
            assign left_rec = '0;
            assign left_vld = 1'b0;
            assign left_ins = 1'b0;
        end else begin : g_body
            assign left_rec = c_rec[g-1];
            assign left_vld = c_vld[g-1];
            assign left_ins = c_ins[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_tail
            assign right_rec = '0;
            assign right_vld = 1'b0;
            assign right_cnt = '0;
        end else begin : g_mid
            assign right_rec = c_rec[g+1];
            assign right_vld = c_vld[g+1];
            assign right_cnt = c_cnt[g+1];
        end

        rsr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new        (new_rec),
            .i_left_rec   (left_rec),
            .i_left_vld   (left_vld),
            .i_left_ins   (left_ins),
            .i_right_rec  (right_rec),
            .i_right_vld  (right_vld),
            .i_right_cnt  (right_cnt),
            .i_ring_score (c_rscore[PREV]),
            .i_ring_vld   (c_rvld[PREV]),
            .o_rec        (c_rec[g]),
            .o_vld        (c_vld[g]),
            .o_ins        (c_ins[g]),
            .o_cnt        (c_cnt[g]),
            .o_ring_score (c_rscore[g]),
            .o_ring_vld   (c_rvld[g])
        );
    end

    // Sequence load, rank and drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_step  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (room)
                            r_count <= r_count + 1'b1;
                        else
                            r_drop <= 1'b1;
                        if (i_is_last)
                            r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_step  <= '0;
                    r_state <= S_RANK;
                end
                S_RANK: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(MAX_RECORDS - 1))
                        r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_valid <= 1'b1;
                    r_count <= r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        r_drop  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Register the head cell as the result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            o_out_id    <= c_rec[0].id;
            o_out_name  <= c_rec[0].name;
            o_out_score <= c_rec[0].score;
            o_out_rank  <= c_cnt[0] + 1'b1;
            o_out_last  <= (r_count == CNT_W'(1));
            o_overflow  <= r_drop;
        end
    end

endmodule
